### hw/rtl/bus_message_block_list_assert.svh
// Assertion macros used by the blocked-message list RTL.
`ifndef BUS_MESSAGE_BLOCK_LIST_ASSERT_SVH
`define BUS_MESSAGE_BLOCK_LIST_ASSERT_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define BMBL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bmbl assertion failed");
// Condition that must never be seen outside reset.
`define BMBL_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("bmbl forbidden condition seen");
`else
`define BMBL_ASSERT(lbl, prop)
`define BMBL_NEVER(lbl, cond)
`endif
`endif

### hw/rtl/bmbl_pkg.sv
// Shared constants, codes and link types for the blocked-message list.
`default_nettype none
package bmbl_pkg;
  localparam int ENTRIES   = 16;
  localparam int MAX_WORDS = 32;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int WW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int SW = $clog2(MAX_WORDS + 1);

  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_DEL   = 2'd1;
  localparam logic [1:0] KIND_CHECK = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_FULL    = 3'd1;
  localparam logic [2:0] STAT_OWN     = 3'd2;
  localparam logic [2:0] STAT_PRESENT = 3'd3;
  localparam logic [2:0] STAT_MISSING = 3'd4;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic [WW-1:0] ra;
    logic [WW-1:0] wa;
    logic          step;
    logic          pos0;
    logic          tx;
    logic          is_check;
    logic          add_wr;
    logic          shift_wr;
    logic          cmd_load;
    logic          cmd_shift;
    logic [15:0]   cmd;
    logic [15:0]   dw;
    logic [15:0]   mw;
  } cell_ctl_t;

  // What a cell hands to its lower neighbor: command and the word just read.
  typedef struct packed {
    logic [15:0] cmd;
    logic [31:0] rdata;
  } cell_link_t;
endpackage
`default_nettype wire

### hw/rtl/bmbl_cell.sv
// One list entry: command, word memory and match flags, linked to its neighbor.
`default_nettype none
module bmbl_cell (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire bmbl_pkg::cell_ctl_t  ctl,
  input  wire logic                 live,
  input  wire logic                 sel_add,
  input  wire logic                 sel_shift,
  input  wire bmbl_pkg::cell_link_t nbr,
  output bmbl_pkg::cell_link_t      link,
  output logic                      match_now,
  output logic                      seen_now
);
  import bmbl_pkg::*;

  logic [31:0] mem [MAX_WORDS];
  logic [31:0] rdata_r;
  logic [15:0] cmd_r;
  logic        flag_r;
  logic        seen_r;
  logic        wr_en;
  logic [31:0] wdata;
  logic [15:0] sd;
  logic [15:0] sm;
  logic        base;

  // Word memory: data in the upper half, mask in the lower half.
  assign wr_en = (ctl.add_wr && sel_add) || (ctl.shift_wr && sel_shift);
  assign wdata = ctl.shift_wr ? nbr.rdata : {ctl.dw, ctl.mw};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ctl.wa] <= wdata;
    end
    rdata_r <= mem[ctl.ra];
  end

  // Command register, loaded on a committed add or pulled down on a delete.
  always_ff @(posedge clk) begin
    if (ctl.cmd_load && sel_add) begin
      cmd_r <= ctl.cmd;
    end else if (ctl.cmd_shift && sel_shift) begin
      cmd_r <= nbr.cmd;
    end
  end

  assign link.cmd   = cmd_r;
  assign link.rdata = rdata_r;

  // Compare the current word against this entry.
  assign sd = rdata_r[31:16];
  assign sm = rdata_r[15:0];

  always_comb begin
    base     = ctl.pos0 ? (live && (cmd_r == ctl.cmd)) : flag_r;
    seen_now = ctl.pos0 ? 1'b0 : seen_r;
    if (ctl.tx) begin
      if (ctl.is_check) begin
        if (sm != 16'h0000) begin
          seen_now = seen_now | base;
          if ((ctl.dw & sm) != (sd & sm)) begin
            base = 1'b0;
          end
        end
      end else if ((sd != ctl.dw) || (sm != ctl.mw)) begin
        base = 1'b0;
      end
    end
    match_now = base;
  end

  // Flags carry across the words of one message.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= 1'b0;
      seen_r <= 1'b0;
    end else if (ctl.step) begin
      flag_r <= match_now;
      seen_r <= seen_now;
    end
  end
endmodule
`default_nettype wire

### hw/rtl/bus_message_block_list.sv
// Blocked-message list for a 1553 remote terminal: a chain of entry cells.
// Usage: each request on the in_ channel carries one word of a message
// (kind, command, data word, mask word). A receive command is one request;
// a transmit command takes its word count (0 means 32) requests, and only
// the last one gives a result on the out_ channel: status, prohibited flag
// and the entry count after the operation. Clear acts at once.
// Timing: a request is accepted only when the sequencer is idle; its words
// are read from all cells in parallel at the accept edge and compared in
// the next cycle (the compare state); a finished message registers its
// result into the output register when it leaves the compare state. A delete
// that removes an entry then moves the following entries down one cell,
// one word a cycle for all cells at once, and no request is accepted
// until that move is done.
// The result sits in an output register; when the receiver stalls, the
// next request may still be accepted and compared, and the block holds in
// its compare cycle only if that request would give another result.
// Reset (synchronous, active low) empties the list, clears the word position
// and sets the own terminal address to 0. cfg_ready is always high. The
// user must write cfg_data only while idle; the block does not enforce it.
`default_nettype none
`include "bus_message_block_list_assert.svh"
module bus_message_block_list (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_kind,
  input  wire logic [15:0] in_command,
  input  wire logic [15:0] in_data_word,
  input  wire logic [15:0] in_mask_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic             out_prohibited,
  output logic [4:0]       out_entry_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_data
);
  import bmbl_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CMP   = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [1:0]    kind_r;
  logic [15:0]   cmd_r, dw_r, mw_r;
  logic [4:0]    own_r;
  logic [WW-1:0] pos_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] sw_r;
  logic [ENTRIES-1:0] shsel_r, pref, live, nlive, sel_add, sel_shift, match, seen;
  logic          out_valid_r;
  logic [2:0]    status_r, status_c;
  logic          proh_r, proh_c;
  logic [4:0]    outcnt_r;
  logic          tx, clear, full, any, last, fin, go;
  logic [5:0]    sz_raw, size;
  cell_ctl_t     ctl;
  cell_link_t    links [ENTRIES];
  cell_link_t    nbrs  [ENTRIES];

  assign cfg_ready       = 1'b1;
  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_prohibited  = proh_r;
  assign out_entry_count = outcnt_r;

  // Message length from the current command.
  assign tx     = cmd_r[10];
  assign clear  = (kind_r == KIND_CLEAR);
  assign sz_raw = (cmd_r[4:0] == 5'd0) ? 6'd32 : {1'b0, cmd_r[4:0]};
  assign size   = !tx ? 6'd1 : ((sz_raw > 6'(MAX_WORDS)) ? 6'(MAX_WORDS) : sz_raw);
  assign last   = (7'(pos_r) + 7'd1) >= 7'(size);
  assign fin    = clear || last;
  assign go     = (state_r == ST_CMP) && (!fin || !out_valid_r || out_ready);
  assign full   = cnt_r >= CW'(ENTRIES);
  assign any    = |match;

  // Per-cell selects. Only cells from the first match on whose upper neighbor
  // holds a live entry pull from that neighbor on a delete.
  always_comb begin
    for (int e = 0; e < ENTRIES; e++) begin
      live[e]    = CW'(e) < cnt_r;
      nlive[e]   = CW'(e + 1) < cnt_r;
      sel_add[e] = cnt_r == CW'(e);
    end
    pref[0] = match[0];
    for (int e = 1; e < ENTRIES; e++) begin
      pref[e] = pref[e-1] | match[e];
    end
    sel_shift = (state_r == ST_SHIFT) ? shsel_r : (pref & nlive);
  end

  // Completion of the current message.
  always_comb begin
    status_c = STAT_OK;
    proh_c   = 1'b0;
    cnt_nxt  = cnt_r;
    case (kind_r)
      KIND_ADD: begin
        if (full) begin
          status_c = STAT_FULL;
        end else if (cmd_r[15:11] == own_r) begin
          status_c = STAT_OWN;
        end else if (any) begin
          status_c = STAT_PRESENT;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      KIND_DEL: begin
        if (!any) begin
          status_c = STAT_MISSING;
        end else if (cnt_r != '0) begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      KIND_CHECK: begin
        proh_c = tx ? |(match & seen) : any;
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  // Control broadcast to the cell chain.
  always_comb begin
    ctl.ra        = (state_r == ST_SHIFT) ? sw_r[WW-1:0] : pos_r;
    ctl.wa        = (state_r == ST_SHIFT) ? WW'(sw_r - SW'(1)) : pos_r;
    ctl.step      = go && !clear;
    ctl.pos0      = (pos_r == '0);
    ctl.tx        = tx;
    ctl.is_check  = (kind_r == KIND_CHECK);
    ctl.add_wr    = go && (kind_r == KIND_ADD) && tx && !full;
    ctl.shift_wr  = (state_r == ST_SHIFT) && (sw_r != '0);
    ctl.cmd_load  = go && fin && (kind_r == KIND_ADD) && (status_c == STAT_OK);
    ctl.cmd_shift = go && fin && (kind_r == KIND_DEL) && any;
    ctl.cmd       = cmd_r;
    ctl.dw        = dw_r;
    ctl.mw        = mw_r;
  end

  // The chain of entry cells; the last cell pulls zeros.
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    if (g == ENTRIES - 1) begin : g_end
      assign nbrs[g] = '0;
    end else begin : g_mid
      assign nbrs[g] = links[g+1];
    end
    bmbl_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .live      (live[g]),
      .sel_add   (sel_add[g]),
      .sel_shift (sel_shift[g]),
      .nbr       (nbrs[g]),
      .link      (links[g]),
      .match_now (match[g]),
      .seen_now  (seen[g])
    );
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (go) begin
          state_nxt = (fin && (kind_r == KIND_DEL) && any) ? ST_SHIFT : ST_IDLE;
        end
      end
      ST_SHIFT: begin
        if (sw_r == SW'(MAX_WORDS)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Request capture, result registers and shift selects.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r <= in_kind;
      cmd_r  <= in_command;
      dw_r   <= in_data_word;
      mw_r   <= in_mask_word;
    end
    if (go && fin) begin
      status_r <= status_c;
      proh_r   <= proh_c;
      outcnt_r <= 5'(cnt_nxt);
    end
    if (go && fin) begin
      shsel_r <= pref & nlive;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      cnt_r       <= '0;
      sw_r        <= '0;
      out_valid_r <= 1'b0;
      own_r       <= 5'd0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        own_r <= cfg_data;
      end
      if (go && fin) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (go) begin
        if (fin) begin
          pos_r <= '0;
          cnt_r <= cnt_nxt;
        end else begin
          pos_r <= pos_r + WW'(1);
        end
      end
      if (state_r == ST_SHIFT) begin
        sw_r <= sw_r + SW'(1);
      end else begin
        sw_r <= '0;
      end
    end
  end

  `BMBL_ASSERT(a_cnt_bound, cnt_r <= CW'(ENTRIES))
  `BMBL_NEVER(a_no_accept_in_shift, (state_r == ST_SHIFT) && in_ready)
  `BMBL_ASSERT(a_del_drops_one, ctl.cmd_shift |=> (cnt_r == $past(cnt_r) - CW'(1)))
  `BMBL_ASSERT(a_result_only_at_end, (go && !fin) |=> (pos_r != '0))
endmodule
`default_nettype wire
